### rtl/core/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned CNT_OUT_W = 5;
    localparam int unsigned S_DATA_W  = 32;
    localparam int unsigned M_DATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_REVERSE   = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/bounded_deque_with_reverse_top.sv
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------------
// s        | in  | s_tvalid/s_tready  | s_tuser: command; s_tdata: value
// m        | out | m_tvalid/m_tready  | m_tuser: ok; m_tdata: removed_value, count
//
// At most one command is in flight: the accept beat updates the pointers and issues
// the element RAM access; the result register then loads from the RAM's registered
// read port once the m side has room. Reverse only flips a direction flag.
// Reset (rst_n low, async) empties the queue and clears the direction flag.
// s_tready is low from each accept until the result register loads; a stalled
// m side holds one result while one more command waits in the datapath.
`default_nettype none

module bounded_deque_with_reverse_top
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [CMD_W-1:0]    s_tuser,   // [1:0] command
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [31:0] removed_value, [36:32] count
    output logic                     m_tuser    // [0] ok
);

    ctl_t  ctl;
    stat_t stat;
    logic [VAL_W-1:0]     removed;
    logic [CNT_OUT_W-1:0] count;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_ok      (m_tuser),
        .out_removed (removed),
        .out_count   (count)
    );

    assign m_tdata = {(M_DATA_W - VAL_W - CNT_OUT_W)'(0), count, removed};

endmodule

`default_nettype wire

### rtl/core/bdq_ram.sv
`default_nettype none

module bdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/bdq_ctrl.sv
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output ctl_t       ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctl.accept   = 1'b0;
        ctl.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
            end
            ST_RESULT:
            begin
                ctl.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/bdq_datapath.sv
`default_nettype none

module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_t                 ctl,
    output stat_t                     stat,
    input  wire logic [CMD_W-1:0]     in_cmd,
    input  wire logic [VAL_W-1:0]     in_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_ok,
    output logic [VAL_W-1:0]          out_removed,
    output logic [CNT_OUT_W-1:0]      out_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          ok_reg, ok_next;
    logic          pop_reg, pop_next;
    logic          out_valid_reg;
    logic          out_ok_reg;
    logic [VAL_W-1:0]     out_removed_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;

    cmd_t          cmd;
    logic          full;
    logic          empty;
    logic          is_push;
    logic          at_front;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] last_slot;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    assign cmd      = cmd_t'(in_cmd);
    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign is_push  = cmd inside {CMD_PUSH_HEAD, CMD_PUSH_TAIL};
    // head push with normal order, or tail push when reversed, goes before the span
    assign at_front = ((cmd == CMD_PUSH_HEAD) == !rev_reg);

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);

    // both sums stay below twice the depth, so one compare and subtract wraps them
    assign tail_sum  = {1'b0, front_reg} + SW'(count_reg);
    assign last_sum  = tail_sum - SW'(1);
    assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign last_slot = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        ok_next    = ok_reg;
        pop_next   = pop_reg;
        ram_we     = 1'b0;
        ram_waddr  = at_front ? front_dec : tail_slot;
        ram_re     = 1'b0;
        ram_raddr  = rev_reg ? last_slot : front_reg;
        if (ctl.accept)
        begin
            ok_next  = 1'b1;
            pop_next = 1'b0;
            case (cmd)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL:
                begin
                    if (full)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        ram_we     = is_push;
                        count_next = count_reg + CW'(1);
                        if (at_front)
                        begin
                            front_next = front_dec;
                        end
                    end
                end
                CMD_POP_HEAD:
                begin
                    if (empty)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        pop_next   = 1'b1;
                        count_next = count_reg - CW'(1);
                        if (!rev_reg)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        pop_reg <= pop_next;
        if (ctl.load_out)
        begin
            out_ok_reg      <= ok_reg;
            out_removed_reg <= pop_reg ? ram_rdata : '0;
            out_count_reg   <= CNT_OUT_W'(count_reg);
        end
    end

    bdq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_ok        = out_ok_reg;
    assign out_removed   = out_removed_reg;
    assign out_count     = out_count_reg;

endmodule

`default_nettype wire

### rtl/core/bdq_checker.sv
`default_nettype none

module bdq_checker
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic [CMD_W-1:0]    s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a failed command never reports a removed value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("failed command with nonzero removed value");

    // only one command in flight: no accept on the beat right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");

    // count never exceeds capacity when it fits the field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 32) |-> m_tdata[36:32] <= CNT_OUT_W'(DEPTH))
        else $error("count above capacity");

endmodule

bind bounded_deque_with_reverse_top bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
